// ===== sv/qvr_pkg.sv =====
// ----------------------------------------------------------------------------
// qvr_pkg: shared types and constants for the quaternion vector rotate unit
// fixed-point widths, transfer payload structs and the hamilton term tables
// ----------------------------------------------------------------------------
`default_nettype none

package qvr_pkg;

	// fraction bits of a unit quaternion component (q2.24)
	localparam int UNIT_FRAC = 24;

	// normalizer widths
	localparam int SQ_W      = 31;                 // one q2.14 component squared
	localparam int N2_W      = SQ_W + 2;           // sum of four squares
	localparam int RAD_SHIFT = 28;
	localparam int RAD_W     = N2_W + RAD_SHIFT;   // radicand of the square root
	localparam int LEN_W     = (RAD_W + 1) / 2;    // root bits, one per stage
	localparam int TRY_W     = RAD_W + 3;          // trial value, headroom for the shift
	localparam int MAG_W     = 16;
	localparam int NUM_SHIFT = 38;
	localparam int QUO_W     = UNIT_FRAC + 1;      // quotient never exceeds one unit
	localparam int DIV_W     = LEN_W + QUO_W;      // remainder and shifted divisor
	localparam int U_W       = QUO_W + 1;          // signed unit component

	// rotation datapath widths
	localparam int V_W  = 32;
	localparam int P1_W = U_W + V_W;               // unit times vector
	localparam int T_W  = P1_W - UNIT_FRAC;        // first product after the shift
	localparam int P2_W = T_W + U_W;               // intermediate times unit
	localparam int S2_W = P2_W + 1;                // sum of four terms
	localparam int R_W  = S2_W - UNIT_FRAC;        // second product after the shift

	// first product t = u * (v, 0): row i of t, term j multiplies u[H1_IDX] by v[j]
	localparam logic [1:0] H1_IDX [4][3] = '{
		'{2'd3, 2'd2, 2'd1},
		'{2'd2, 2'd3, 2'd0},
		'{2'd1, 2'd0, 2'd3},
		'{2'd0, 2'd1, 2'd2}
	};
	// bit j set: term j is subtracted
	localparam logic [2:0] H1_NEG [4] = '{3'b010, 3'b100, 3'b001, 3'b111};

	// second product r = t * conj(u): row r, term k multiplies t[k] by u[H2_IDX]
	localparam logic [1:0] H2_IDX [3][4] = '{
		'{2'd3, 2'd2, 2'd1, 2'd0},
		'{2'd2, 2'd3, 2'd0, 2'd1},
		'{2'd1, 2'd0, 2'd3, 2'd2}
	};
	localparam logic [3:0] H2_NEG [3] = '{4'b1010, 4'b1100, 4'b1001};

	typedef struct packed {
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
		logic signed [15:0] quat_w;
		logic signed [31:0] vec_x;
		logic signed [31:0] vec_y;
		logic signed [31:0] vec_z;
	} qvr_in_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic               clipped;
		logic               zero_quat;
	} qvr_res_t;

	// item data that rides along the normalizer pipeline
	typedef struct packed {
		qvr_in_t item;
		logic    zero;
	} qvr_carry_t;

endpackage

`default_nettype wire

// ===== sv/qvr_norm.sv =====
// ----------------------------------------------------------------------------
// qvr_norm: quaternion normalizer
// squares, a one-bit-per-stage square root and four one-bit-per-stage
// dividers; all stages advance together on adv
// ----------------------------------------------------------------------------
`default_nettype none

module qvr_norm (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           adv,
	input  wire logic                           in_vld,
	input  wire qvr_pkg::qvr_in_t               in_item,
	output logic                                out_vld,
	output qvr_pkg::qvr_carry_t                 out_carry,
	output logic signed [qvr_pkg::U_W-1:0]      unit [4]
);
	import qvr_pkg::*;

	logic signed [15:0]     qin [4];
	logic signed [31:0]     sq_c [4];
	logic [N2_W-1:0]        n2_c;

	// stage 1: squares
	logic                   vld_s1;
	logic [SQ_W-1:0]        sq_s1 [4];
	qvr_in_t                item_s1;

	// square root stages
	logic                   rt_vld_s [LEN_W+1];
	logic [RAD_W-1:0]       rt_rem_s [LEN_W+1];
	logic [LEN_W-1:0]       rt_root_s [LEN_W+1];
	qvr_carry_t             rt_c_s [LEN_W+1];
	logic [RAD_W-1:0]       rt_rem_n [LEN_W+1];
	logic [LEN_W-1:0]       rt_root_n [LEN_W+1];
	logic [TRY_W-1:0]       rt_try [LEN_W];

	// divider stages
	logic                   dv_vld_s [QUO_W+1];
	logic [LEN_W-1:0]       dv_len_s [QUO_W+1];
	logic [DIV_W-1:0]       dv_rem_s [QUO_W+1][4];
	logic [QUO_W-1:0]       dv_quo_s [QUO_W+1][4];
	qvr_carry_t             dv_c_s [QUO_W+1];
	logic [DIV_W-1:0]       dv_rem_n [QUO_W+1][4];
	logic [QUO_W-1:0]       dv_quo_n [QUO_W+1][4];
	logic [DIV_W-1:0]       dv_div [QUO_W];
	logic [DIV_W-1:0]       dv_num [4];
	logic [MAG_W-1:0]       mag [4];
	logic                   sgn [4];

	// output stage
	logic                   vld_su;
	qvr_carry_t             c_su;
	logic signed [U_W-1:0]  u_su [4];
	logic signed [U_W-1:0]  u_n [4];

	assign qin[0] = in_item.quat_x;
	assign qin[1] = in_item.quat_y;
	assign qin[2] = in_item.quat_z;
	assign qin[3] = in_item.quat_w;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			sq_c[i] = qin[i] * qin[i];
		end
		n2_c = N2_W'(sq_s1[0]) + N2_W'(sq_s1[1]) + N2_W'(sq_s1[2]) + N2_W'(sq_s1[3]);
	end

	// square root: try root bit i, keep rem = radicand - root^2
	always_comb begin
		rt_rem_n[0]  = rt_rem_s[0];
		rt_root_n[0] = rt_root_s[0];
		for (int k = 0; k < LEN_W; k++) begin
			rt_try[k] = (TRY_W'(rt_root_s[k]) << (LEN_W - k))
				+ (TRY_W'(1) << (2 * (LEN_W - 1 - k)));
			if (TRY_W'(rt_rem_s[k]) >= rt_try[k]) begin
				rt_rem_n[k+1]  = rt_rem_s[k] - rt_try[k][RAD_W-1:0];
				rt_root_n[k+1] = rt_root_s[k] | (LEN_W'(1) << (LEN_W - 1 - k));
			end else begin
				rt_rem_n[k+1]  = rt_rem_s[k];
				rt_root_n[k+1] = rt_root_s[k];
			end
		end
	end

	// restoring division, one quotient bit a stage
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			dv_rem_n[0][c] = dv_rem_s[0][c];
			dv_quo_n[0][c] = dv_quo_s[0][c];
		end
		for (int j = 0; j < QUO_W; j++) begin
			dv_div[j] = DIV_W'(dv_len_s[j]) << (QUO_W - 1 - j);
			for (int c = 0; c < 4; c++) begin
				if (dv_rem_s[j][c] >= dv_div[j]) begin
					dv_rem_n[j+1][c] = dv_rem_s[j][c] - dv_div[j];
					dv_quo_n[j+1][c] = {dv_quo_s[j][c][QUO_W-2:0], 1'b1};
				end else begin
					dv_rem_n[j+1][c] = dv_rem_s[j][c];
					dv_quo_n[j+1][c] = {dv_quo_s[j][c][QUO_W-2:0], 1'b0};
				end
			end
		end
	end

	// magnitudes and signs at the divider load
	always_comb begin
		sgn[0] = rt_c_s[LEN_W].item.quat_x[15];
		sgn[1] = rt_c_s[LEN_W].item.quat_y[15];
		sgn[2] = rt_c_s[LEN_W].item.quat_z[15];
		sgn[3] = rt_c_s[LEN_W].item.quat_w[15];
		mag[0] = sgn[0] ? MAG_W'(-rt_c_s[LEN_W].item.quat_x) : MAG_W'(rt_c_s[LEN_W].item.quat_x);
		mag[1] = sgn[1] ? MAG_W'(-rt_c_s[LEN_W].item.quat_y) : MAG_W'(rt_c_s[LEN_W].item.quat_y);
		mag[2] = sgn[2] ? MAG_W'(-rt_c_s[LEN_W].item.quat_z) : MAG_W'(rt_c_s[LEN_W].item.quat_z);
		mag[3] = sgn[3] ? MAG_W'(-rt_c_s[LEN_W].item.quat_w) : MAG_W'(rt_c_s[LEN_W].item.quat_w);
		for (int c = 0; c < 4; c++) begin
			dv_num[c] = DIV_W'({mag[c], {NUM_SHIFT{1'b0}}});
		end
	end

	// signs back on, identity for the all-zero quaternion
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			if (dv_c_s[QUO_W].zero) begin
				u_n[c] = (c == 3) ? (U_W'(1) << UNIT_FRAC) : '0;
			end else if (dv_c_s[QUO_W].item.quat_x[15] && c == 0
				|| dv_c_s[QUO_W].item.quat_y[15] && c == 1
				|| dv_c_s[QUO_W].item.quat_z[15] && c == 2
				|| dv_c_s[QUO_W].item.quat_w[15] && c == 3) begin
				u_n[c] = -signed'(U_W'(dv_quo_s[QUO_W][c]));
			end else begin
				u_n[c] = signed'(U_W'(dv_quo_s[QUO_W][c]));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_su <= 1'b0;
			for (int k = 0; k <= LEN_W; k++) rt_vld_s[k] <= 1'b0;
			for (int j = 0; j <= QUO_W; j++) dv_vld_s[j] <= 1'b0;
		end else if (adv) begin
			vld_s1      <= in_vld;
			rt_vld_s[0] <= vld_s1;
			for (int k = 0; k < LEN_W; k++) rt_vld_s[k+1] <= rt_vld_s[k];
			dv_vld_s[0] <= rt_vld_s[LEN_W];
			for (int j = 0; j < QUO_W; j++) dv_vld_s[j+1] <= dv_vld_s[j];
			vld_su      <= dv_vld_s[QUO_W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= in_item;
			for (int i = 0; i < 4; i++) sq_s1[i] <= sq_c[i][SQ_W-1:0];

			rt_rem_s[0]     <= {n2_c, {RAD_SHIFT{1'b0}}};
			rt_root_s[0]    <= '0;
			rt_c_s[0].item  <= item_s1;
			rt_c_s[0].zero  <= (n2_c == '0);
			for (int k = 0; k < LEN_W; k++) begin
				rt_rem_s[k+1]  <= rt_rem_n[k+1];
				rt_root_s[k+1] <= rt_root_n[k+1];
				rt_c_s[k+1]    <= rt_c_s[k];
			end

			dv_len_s[0] <= rt_root_s[LEN_W];
			dv_c_s[0]   <= rt_c_s[LEN_W];
			for (int c = 0; c < 4; c++) begin
				dv_rem_s[0][c] <= dv_num[c];
				dv_quo_s[0][c] <= '0;
			end
			for (int j = 0; j < QUO_W; j++) begin
				dv_len_s[j+1] <= dv_len_s[j];
				dv_c_s[j+1]   <= dv_c_s[j];
				for (int c = 0; c < 4; c++) begin
					dv_rem_s[j+1][c] <= dv_rem_n[j+1][c];
					dv_quo_s[j+1][c] <= dv_quo_n[j+1][c];
				end
			end

			c_su <= dv_c_s[QUO_W];
			for (int c = 0; c < 4; c++) u_su[c] <= u_n[c];
		end
	end

	assign out_vld   = vld_su;
	assign out_carry = c_su;
	always_comb begin
		for (int c = 0; c < 4; c++) unit[c] = u_su[c];
	end

endmodule

`default_nettype wire

// ===== sv/quaternion_vector_rotate_unit.sv =====
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_unit: rotates a q16.16 vector by a q2.14 quaternion
// normalizes the quaternion, then forms u * (v, 0) * conj(u) with saturation
// ----------------------------------------------------------------------------
// usage
//   item channel: item_valid / item / item_stall carries one quaternion and
//   one vector per transfer; result channel: result_valid / result /
//   result_stall returns exactly one rotated vector per item, in order
//   throughput: one item per clock cycle with no stall on the result side
//   from the item transfer to result_valid, an item passes the square
//   root (one root bit per stage) and the dividers (one quotient bit per
//   stage) inside the normalizer, then five rotation stages
//   an all-zero quaternion is replaced by the identity and flags zero_quat;
//   any component beyond the 32-bit range saturates and flags clipped
//   reset clears all valid bits; the pipeline comes up empty and ready
//   when result_stall holds a waiting result, the whole pipeline freezes,
//   item_stall rises, and nothing is lost or repeated
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_vector_rotate_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	input  wire qvr_pkg::qvr_in_t  item,
	output logic                   item_stall,
	output logic                   result_valid,
	output qvr_pkg::qvr_res_t      result,
	input  wire logic              result_stall
);
	import qvr_pkg::*;

	// global advance: everything moves unless a finished result is held back
	logic adv;

	// normalizer outputs
	logic                   nrm_vld;
	qvr_carry_t             nrm_c;
	logic signed [U_W-1:0]  nrm_u [4];
	logic signed [V_W-1:0]  vin [3];

	// stage 1: unit times vector products
	logic                   vld_s1;
	logic                   zero_s1;
	logic signed [U_W-1:0]  u_s1 [4];
	logic signed [P1_W-1:0] m_s1 [4][3];

	// stage 2: first hamilton product, truncated toward zero
	logic                   vld_s2;
	logic                   zero_s2;
	logic signed [U_W-1:0]  u_s2 [4];
	logic signed [T_W-1:0]  t_s2 [4];
	logic signed [P1_W-1:0] sum1 [4];
	logic signed [P1_W-1:0] adj1 [4];

	// stage 3: intermediate times unit products
	logic                   vld_s3;
	logic                   zero_s3;
	logic signed [P2_W-1:0] m_s3 [3][4];

	// stage 4: second hamilton product
	logic                   vld_s4;
	logic                   zero_s4;
	logic signed [R_W-1:0]  r_s4 [3];
	logic signed [S2_W-1:0] sum2 [3];
	logic signed [S2_W-1:0] adj2 [3];

	// stage 5: saturated output register
	logic                   vld_s5;
	qvr_res_t               res_s5;
	logic signed [31:0]     sat [3];
	logic [2:0]             ovf;

	assign adv        = !(vld_s5 && result_stall);
	assign item_stall = !adv;

	qvr_norm u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_vld    (item_valid),
		.in_item   (item),
		.out_vld   (nrm_vld),
		.out_carry (nrm_c),
		.unit      (nrm_u)
	);

	assign vin[0] = nrm_c.item.vec_x;
	assign vin[1] = nrm_c.item.vec_y;
	assign vin[2] = nrm_c.item.vec_z;

	// signed sums, then add 2^24-1 to negatives so the shift truncates toward zero
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			sum1[i] = '0;
			for (int j = 0; j < 3; j++) begin
				if (H1_NEG[i][j]) sum1[i] = sum1[i] - m_s1[i][j];
				else              sum1[i] = sum1[i] + m_s1[i][j];
			end
			adj1[i] = sum1[i] + (sum1[i][P1_W-1] ? P1_W'((64'd1 << UNIT_FRAC) - 64'd1) : '0);
		end
		for (int r = 0; r < 3; r++) begin
			sum2[r] = '0;
			for (int k = 0; k < 4; k++) begin
				if (H2_NEG[r][k]) sum2[r] = sum2[r] - S2_W'(m_s3[r][k]);
				else              sum2[r] = sum2[r] + S2_W'(m_s3[r][k]);
			end
			adj2[r] = sum2[r] + (sum2[r][S2_W-1] ? S2_W'((64'd1 << UNIT_FRAC) - 64'd1) : '0);
		end
	end

	// saturate to the 32-bit range
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			ovf[r] = (r_s4[r][R_W-1:31] != {(R_W-31){r_s4[r][31]}});
			if (!ovf[r])              sat[r] = r_s4[r][31:0];
			else if (r_s4[r][R_W-1])  sat[r] = {1'b1, 31'd0};
			else                      sat[r] = {1'b0, {31{1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= nrm_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			zero_s1 <= nrm_c.zero;
			for (int i = 0; i < 4; i++) begin
				u_s1[i] <= nrm_u[i];
				for (int j = 0; j < 3; j++) begin
					m_s1[i][j] <= nrm_u[H1_IDX[i][j]] * vin[j];
				end
			end

			zero_s2 <= zero_s1;
			for (int i = 0; i < 4; i++) begin
				u_s2[i] <= u_s1[i];
				t_s2[i] <= adj1[i][P1_W-1:UNIT_FRAC];
			end

			zero_s3 <= zero_s2;
			for (int r = 0; r < 3; r++) begin
				for (int k = 0; k < 4; k++) begin
					m_s3[r][k] <= t_s2[k] * u_s2[H2_IDX[r][k]];
				end
			end

			zero_s4 <= zero_s3;
			for (int r = 0; r < 3; r++) r_s4[r] <= adj2[r][S2_W-1:UNIT_FRAC];

			res_s5.out_x     <= sat[0];
			res_s5.out_y     <= sat[1];
			res_s5.out_z     <= sat[2];
			res_s5.clipped   <= |ovf;
			res_s5.zero_quat <= zero_s4;
		end
	end

	assign result_valid = vld_s5;
	assign result       = res_s5;

endmodule

`default_nettype wire
